>>> hw/rtl/fdl_pkg.sv
// Package for the frame drop list block: widths, codes, state type and
// the control struct shared by the top level and its cells, and the result struct.
// Depends on nothing.
package fdl_pkg;

    localparam int ID_W      = 32;
    localparam int FLOW_W    = 8;
    localparam int DEPTH_DEF = 8;
    localparam int FLOWS_DEF = 8;

    localparam logic MODE_CHECK  = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_WALK,
        ST_DONE
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic            wr_en;
        logic [ID_W-1:0] wr_data;
        logic            start;
        logic            kill;
    } t_cell_ctl;

    typedef struct packed {
        logic drop;
        logic older_than_all;
        logic duplicate;
        logic overflow_warn;
        logic bad_flow;
    } t_result;

endpackage

>>> hw/rtl/fdl_in_if.sv
// Request channel of the frame drop list: valid/ready plus the item fields.
// Depends on fdl_pkg.
interface fdl_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [fdl_pkg::FLOW_W-1:0] flow;
    logic [fdl_pkg::ID_W-1:0]   frame_num;

    modport source (output valid, mode, flow, frame_num, input ready);
    modport sink   (input valid, mode, flow, frame_num, output ready);
endinterface

>>> hw/rtl/fdl_out_if.sv
// Result channel of the frame drop list: valid/ready plus the result flags.
// Depends on nothing.
interface fdl_out_if;
    logic valid;
    logic ready;
    logic drop;
    logic older_than_all;
    logic duplicate;
    logic overflow_warn;
    logic bad_flow;

    modport source (output valid, drop, older_than_all, duplicate, overflow_warn,
                    bad_flow, input ready);
    modport sink   (input valid, drop, older_than_all, duplicate, overflow_warn,
                    bad_flow, output ready);
endinterface

>>> hw/rtl/fdl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fdl_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 8,
    localparam int AW   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/fdl_cell.sv
// One ring slot of the drop list for all flows, plus the walk token that
// moves to the neighbor slot below. Depends on fdl_pkg and fdl_ram.
module fdl_cell #(
    parameter int FLOWS = fdl_pkg::FLOWS_DEF,
    localparam int FW   = (FLOWS > 1) ? $clog2(FLOWS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fdl_pkg::t_cell_ctl       i_ctl,
    input  logic [FW-1:0]            i_rd_addr,
    input  logic [FW-1:0]            i_wr_addr,
    input  logic [fdl_pkg::ID_W-1:0] i_id,
    input  logic                     i_tok,
    output logic                     o_tok,
    output logic                     o_stop,
    output logic                     o_found,
    output logic [fdl_pkg::ID_W-1:0] o_entry
);

    logic                     r_tok;
    logic                     n_tok;
    logic [fdl_pkg::ID_W-1:0] entry;

    fdl_ram #(
        .WIDTH (fdl_pkg::ID_W),
        .WORDS (FLOWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_ctl.wr_data),
        .i_raddr (i_rd_addr),
        .o_rdata (entry)
    );

    // compare while holding the token; pass it on only past a newer entry
    assign o_stop  = r_tok && (i_id >= entry);
    assign o_found = r_tok && (i_id == entry);
    assign o_tok   = r_tok && (i_id < entry);
    assign o_entry = entry;

    // take the token at walk start or from the upper neighbor; kill drops it first
    always_comb begin
        priority if (i_ctl.kill) begin
            n_tok = 1'b0;
        end else if (i_ctl.start) begin
            n_tok = 1'b1;
        end else begin
            n_tok = i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

endmodule

>>> hw/rtl/frame_drop_list.sv
// Frame drop list: per-flow ring of frame ids, insert and check requests.
// Insert passes IDLE, LOOK and DONE; a bad flow goes from IDLE straight to DONE; a check
// runs LOOK, then WALK one ring slot per cycle through the cell chain, then DONE.
// One item at a time: a new request is taken only in IDLE, after the last result is loaded.
// Reset: after i_rst_n the RAMs are cleared one flow address per cycle, with ready low;
// the result register starts empty.
module frame_drop_list #(
    parameter int DEPTH = fdl_pkg::DEPTH_DEF,
    parameter int FLOWS = fdl_pkg::FLOWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fdl_in_if.sink    i_req,
    fdl_out_if.source o_rsp
);

    localparam int FW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int HW = $clog2(DEPTH);

    fdl_pkg::t_state    r_state;
    fdl_pkg::t_state    n_state;
    logic [FW-1:0]      r_flow;
    logic               r_mode;
    logic [fdl_pkg::ID_W-1:0] r_id;
    logic [HW-1:0]      r_cnt;
    logic [FW-1:0]      r_clr;
    fdl_pkg::t_result   r_res;
    fdl_pkg::t_result   n_res;
    fdl_pkg::t_result   r_o;
    logic               r_ov;

    fdl_pkg::t_cell_ctl       cell_ctl [DEPTH];
    logic [fdl_pkg::ID_W-1:0] cell_entry [DEPTH];
    logic [DEPTH-1:0]         tok_vec;
    logic [DEPTH-1:0]         stop_vec;
    logic [DEPTH-1:0]         found_vec;

    logic [FW-1:0]            rd_addr;
    logic [FW-1:0]            wr_addr;
    logic                     head_we;
    logic [HW-1:0]            head_wd;
    logic [HW-1:0]            head_q;
    logic                     last_we;
    logic [fdl_pkg::ID_W-1:0] last_wd;
    logic [fdl_pkg::ID_W-1:0] last_q;

    logic                     flow_ok;
    logic                     req_take;
    logic                     out_load;
    logic                     any_stop;
    logic                     any_found;
    logic                     walk_end;
    logic [HW-1:0]            head_nxt;
    logic [HW-1:0]            head_prv;
    logic [fdl_pkg::ID_W-1:0] cur_e;
    logic [fdl_pkg::ID_W-1:0] prv_e;
    logic [fdl_pkg::ID_W-1:0] nxt_e;
    logic                     dup;

    // request decode
    assign flow_ok  = i_req.flow < fdl_pkg::FLOW_W'(FLOWS);
    assign req_take = (r_state == fdl_pkg::ST_IDLE) && i_req.valid;
    assign rd_addr  = (r_state == fdl_pkg::ST_IDLE) ? i_req.flow[FW-1:0] : r_flow;

    // ring neighbors of the head slot
    assign head_nxt = (head_q == HW'(DEPTH - 1)) ? '0 : head_q + HW'(1);
    assign head_prv = (head_q == '0) ? HW'(DEPTH - 1) : head_q - HW'(1);
    assign cur_e    = cell_entry[head_q];
    assign prv_e    = cell_entry[head_prv];
    assign nxt_e    = cell_entry[head_nxt];
    assign dup      = (cur_e == r_id) || (prv_e == r_id);

    assign any_stop  = |stop_vec;
    assign any_found = |found_vec;
    assign walk_end  = any_stop || (r_cnt == HW'(DEPTH - 1));
    assign out_load  = (r_state == fdl_pkg::ST_DONE) && (!r_ov || o_rsp.ready);

    // cell chain: token moves from slot i+1 down to slot i
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fdl_cell #(
            .FLOWS (FLOWS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl[g]),
            .i_rd_addr (rd_addr),
            .i_wr_addr (wr_addr),
            .i_id      (r_id),
            .i_tok     (tok_vec[(g + 1) % DEPTH]),
            .o_tok     (tok_vec[g]),
            .o_stop    (stop_vec[g]),
            .o_found   (found_vec[g]),
            .o_entry   (cell_entry[g])
        );
    end

    fdl_ram #(
        .WIDTH (HW),
        .WORDS (FLOWS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (wr_addr),
        .i_wdata (head_wd),
        .i_raddr (rd_addr),
        .o_rdata (head_q)
    );

    fdl_ram #(
        .WIDTH (fdl_pkg::ID_W),
        .WORDS (FLOWS)
    ) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (last_we),
        .i_waddr (wr_addr),
        .i_wdata (last_wd),
        .i_raddr (rd_addr),
        .o_rdata (last_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fdl_pkg::ST_CLEAR: begin
                if (r_clr == FW'(FLOWS - 1)) begin
                    n_state = fdl_pkg::ST_IDLE;
                end
            end
            fdl_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = flow_ok ? fdl_pkg::ST_LOOK : fdl_pkg::ST_DONE;
                end
            end
            fdl_pkg::ST_LOOK: begin
                n_state = (r_mode == fdl_pkg::MODE_INSERT) ? fdl_pkg::ST_DONE
                                                            : fdl_pkg::ST_WALK;
            end
            fdl_pkg::ST_WALK: begin
                if (walk_end) begin
                    n_state = fdl_pkg::ST_DONE;
                end
            end
            fdl_pkg::ST_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state = fdl_pkg::ST_IDLE;
                end
            end
            default: n_state = fdl_pkg::ST_CLEAR;
        endcase
    end

    // cell control, RAM writes and result flags
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i] = '0;
        end
        wr_addr = r_flow;
        head_we = 1'b0;
        head_wd = head_nxt;
        last_we = 1'b0;
        last_wd = r_id;
        n_res   = r_res;
        unique case (r_state)
            fdl_pkg::ST_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) begin
                    cell_ctl[i].wr_en = 1'b1;
                end
                wr_addr = r_clr;
                head_we = 1'b1;
                head_wd = '0;
                last_we = 1'b1;
                last_wd = '0;
            end
            fdl_pkg::ST_IDLE: begin
                n_res          = '0;
                n_res.bad_flow = !flow_ok;
            end
            fdl_pkg::ST_LOOK: begin
                if (r_mode == fdl_pkg::MODE_INSERT) begin
                    if (dup) begin
                        n_res.duplicate = 1'b1;
                    end else begin
                        // write after the head, swap once if older than the head
                        n_res.overflow_warn = last_q < nxt_e;
                        head_we             = 1'b1;
                        for (int i = 0; i < DEPTH; i++) begin
                            if (HW'(i) == head_nxt) begin
                                cell_ctl[i].wr_en   = 1'b1;
                                cell_ctl[i].wr_data = (cur_e < r_id) ? r_id : cur_e;
                            end
                            if (HW'(i) == head_q && !(cur_e < r_id)) begin
                                cell_ctl[i].wr_en   = 1'b1;
                                cell_ctl[i].wr_data = r_id;
                            end
                        end
                    end
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        cell_ctl[i].start = (HW'(i) == head_q);
                    end
                end
            end
            fdl_pkg::ST_WALK: begin
                if (walk_end) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        cell_ctl[i].kill = 1'b1;
                    end
                    n_res.drop           = any_found;
                    n_res.older_than_all = !any_stop;
                    last_we              = any_found;
                end
            end
            fdl_pkg::ST_DONE: begin
                n_res = r_res;
            end
            default: n_res = r_res;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdl_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fdl_pkg::ST_CLEAR) begin
                r_clr <= r_clr + FW'(1);
            end
            if (r_state == fdl_pkg::ST_WALK) begin
                r_cnt <= r_cnt + HW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (req_take) begin
            r_flow <= i_req.flow[FW-1:0];
            r_mode <= i_req.mode;
            r_id   <= i_req.frame_num;
        end
        if (out_load) begin
            r_o <= r_res;
        end
    end

    assign i_req.ready          = (r_state == fdl_pkg::ST_IDLE);
    assign o_rsp.valid          = r_ov;
    assign o_rsp.drop           = r_o.drop;
    assign o_rsp.older_than_all = r_o.older_than_all;
    assign o_rsp.duplicate      = r_o.duplicate;
    assign o_rsp.overflow_warn  = r_o.overflow_warn;
    assign o_rsp.bad_flow       = r_o.bad_flow;

    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one cell holds the walk token");

    a_tok_walk_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fdl_pkg::ST_WALK) |-> (tok_vec == '0))
        else $error("walk token alive outside the walk");

    a_rsp_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.drop && o_rsp.older_than_all)
                        && !(o_rsp.duplicate && o_rsp.overflow_warn))
        else $error("conflicting result flags");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_rsp.valid)
        else $error("finished item not presented");

endmodule
